// ===== design/srq_pkg.sv =====
// shared types, constants and control word layout for the signed-rank quantile core
`default_nettype none

package srq_pkg;

   // field widths fixed by the interface
   localparam int SIZE_W     = 6;
   localparam int THRESH_W   = 63;
   localparam int MARGIN_W   = 11;
   localparam int COUNT_W    = 64;
   localparam int MAX_SIZE_D = 63;

   // microprogram step addresses
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_CHECK  = 4'd1;
   localparam step_type STEP_CLEAR  = 4'd2;
   localparam step_type STEP_HISET  = 4'd3;
   localparam step_type STEP_RMW    = 4'd4;
   localparam step_type STEP_DRAIN  = 4'd5;
   localparam step_type STEP_SCZERO = 4'd6;
   localparam step_type STEP_SCRD   = 4'd7;
   localparam step_type STEP_SCACC  = 4'd8;
   localparam step_type STEP_OUT    = 4'd9;
   localparam step_type STEP_ZERO   = 4'd10;

   // sum index operations
   typedef enum logic [2:0] {
      W_HOLD = 3'd0,
      W_ZERO = 3'd1,
      W_INC  = 3'd2,
      W_DEC  = 3'd3,
      W_HI   = 3'd4,
      W_STEP = 3'd5
   } w_op_type;

   // rank counter operations
   typedef enum logic [1:0] {
      I_HOLD = 2'd0,
      I_INIT = 2'd1,
      I_NEXT = 2'd2
   } i_op_type;

   // running total operations
   typedef enum logic [1:0] {
      RT_HOLD = 2'd0,
      RT_ZERO = 2'd1,
      RT_ACC  = 2'd2
   } rt_op_type;

   // jump conditions
   typedef enum logic [2:0] {
      C_NEVER     = 3'd0,
      C_ALWAYS    = 3'd1,
      C_NOT_START = 3'd2,
      C_INVALID   = 3'd3,
      C_W_NE_TOP  = 3'd4,
      C_W_NE_I    = 3'd5,
      C_I_NE_N    = 3'd6,
      C_SCAN_GO   = 3'd7
   } cond_type;

   // one control word of the microprogram
   typedef struct packed {
      w_op_type  w_op;
      i_op_type  i_op;
      rt_op_type rt_op;
      logic      clr_wr;
      logic      rmw;
      logic      out_fire;
      logic      out_zero;
      cond_type  cond;
      step_type  target;
   } ctl_word_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic start;
      logic invalid;
      logic w_eq_top;
      logic w_eq_i;
      logic i_eq_n;
      logic scan_stop;
   } flags_type;

endpackage

`default_nettype wire

// ===== design/srq_sequencer.sv =====
// step counter and microprogram table driving the datapath
`default_nettype none

module srq_sequencer (
   input  wire                  clock,
   input  wire                  reset,
   input  srq_pkg::flags_type   flags,
   output srq_pkg::ctl_word_type ctl,
   output logic                 busy
);

   srq_pkg::step_type pc_ff, pc_in;
   logic              cond_met;

   // microprogram table
   function automatic srq_pkg::ctl_word_type rom_word(input srq_pkg::step_type pc);
      srq_pkg::ctl_word_type cw;
      cw.w_op     = srq_pkg::W_HOLD;
      cw.i_op     = srq_pkg::I_HOLD;
      cw.rt_op    = srq_pkg::RT_HOLD;
      cw.clr_wr   = 1'b0;
      cw.rmw      = 1'b0;
      cw.out_fire = 1'b0;
      cw.out_zero = 1'b0;
      cw.cond     = srq_pkg::C_NEVER;
      cw.target   = srq_pkg::STEP_IDLE;
      case (pc)
         srq_pkg::STEP_IDLE: begin
            cw.cond   = srq_pkg::C_NOT_START;
            cw.target = srq_pkg::STEP_IDLE;
         end
         srq_pkg::STEP_CHECK: begin
            cw.w_op   = srq_pkg::W_ZERO;
            cw.i_op   = srq_pkg::I_INIT;
            cw.cond   = srq_pkg::C_INVALID;
            cw.target = srq_pkg::STEP_ZERO;
         end
         srq_pkg::STEP_CLEAR: begin
            cw.w_op   = srq_pkg::W_INC;
            cw.clr_wr = 1'b1;
            cw.cond   = srq_pkg::C_W_NE_TOP;
            cw.target = srq_pkg::STEP_CLEAR;
         end
         srq_pkg::STEP_HISET: begin
            cw.w_op = srq_pkg::W_HI;
         end
         srq_pkg::STEP_RMW: begin
            cw.w_op   = srq_pkg::W_DEC;
            cw.rmw    = 1'b1;
            cw.cond   = srq_pkg::C_W_NE_I;
            cw.target = srq_pkg::STEP_RMW;
         end
         srq_pkg::STEP_DRAIN: begin
            cw.i_op   = srq_pkg::I_NEXT;
            cw.cond   = srq_pkg::C_I_NE_N;
            cw.target = srq_pkg::STEP_HISET;
         end
         srq_pkg::STEP_SCZERO: begin
            cw.w_op  = srq_pkg::W_ZERO;
            cw.rt_op = srq_pkg::RT_ZERO;
         end
         srq_pkg::STEP_SCRD: begin
            cw.cond = srq_pkg::C_NEVER;
         end
         srq_pkg::STEP_SCACC: begin
            cw.w_op   = srq_pkg::W_STEP;
            cw.rt_op  = srq_pkg::RT_ACC;
            cw.cond   = srq_pkg::C_SCAN_GO;
            cw.target = srq_pkg::STEP_SCRD;
         end
         srq_pkg::STEP_OUT: begin
            cw.out_fire = 1'b1;
            cw.cond     = srq_pkg::C_ALWAYS;
            cw.target   = srq_pkg::STEP_IDLE;
         end
         srq_pkg::STEP_ZERO: begin
            cw.out_fire = 1'b1;
            cw.out_zero = 1'b1;
            cw.cond     = srq_pkg::C_ALWAYS;
            cw.target   = srq_pkg::STEP_IDLE;
         end
         default: begin
            cw.cond   = srq_pkg::C_ALWAYS;
            cw.target = srq_pkg::STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

   assign ctl  = rom_word(pc_ff);
   assign busy = (pc_ff != srq_pkg::STEP_IDLE);

   // jump condition select
   always_comb begin
      case (ctl.cond)
         srq_pkg::C_NEVER:     cond_met = 1'b0;
         srq_pkg::C_ALWAYS:    cond_met = 1'b1;
         srq_pkg::C_NOT_START: cond_met = !flags.start;
         srq_pkg::C_INVALID:   cond_met = flags.invalid;
         srq_pkg::C_W_NE_TOP:  cond_met = !flags.w_eq_top;
         srq_pkg::C_W_NE_I:    cond_met = !flags.w_eq_i;
         srq_pkg::C_I_NE_N:    cond_met = !flags.i_eq_n;
         srq_pkg::C_SCAN_GO:   cond_met = !flags.scan_stop;
         default:              cond_met = 1'b0;
      endcase
   end

   // next step: jump target or fall through
   assign pc_in = cond_met ? ctl.target : pc_ff + srq_pkg::step_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= srq_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/srq_datapath.sv =====
// count store, index counters, running total and threshold compare
`default_nettype none

module srq_datapath #(
   parameter int MAX_SIZE = srq_pkg::MAX_SIZE_D
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            accept,
   input  wire                            start,
   input  wire [srq_pkg::SIZE_W-1:0]      req_sample_size,
   input  wire [srq_pkg::THRESH_W-1:0]    req_threshold,
   input  srq_pkg::ctl_word_type          ctl,
   output srq_pkg::flags_type             flags,
   output logic                           rsp_valid,
   output logic [srq_pkg::MARGIN_W-1:0]   rsp_margin
);

   localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2 + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = srq_pkg::COUNT_W;
   localparam int SW    = srq_pkg::SIZE_W;

   logic [CW-1:0] sum_counts_ff [DEPTH];

   logic [SW-1:0]                  n_ff, i_ff, i_in;
   logic [srq_pkg::THRESH_W-1:0]   thr_ff;
   logic [CW-1:0]                  thr_scaled_ff, thr_scaled_in;
   logic [AW-1:0]                  w_ff, w_in, top_ff, top_in, tri_ff, tri_in;
   logic [AW-1:0]                  wr_addr_ff, rd_b_addr, hi_val;
   logic                           pend_ff;
   logic [CW-1:0]                  rd_a_ff, rd_b_ff, rt_ff, rt_in, rt_sum;
   logic                           rsp_valid_ff;
   logic [srq_pkg::MARGIN_W-1:0]   rsp_margin_ff;
   logic [SW-1:0]                  shift_amt;
   logic [CW-1:0]                  thr_ext, thr_mask;
   logic [2*SW-1:0]                tri_prod;
   logic                           hit;

   // request word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff   <= req_sample_size;
         thr_ff <= req_threshold;
      end
   end

   // threshold scaled down by 2^(63-n), rounded up, so the scan compares raw counts
   assign shift_amt     = SW'(63) - n_ff;
   assign thr_ext       = {1'b0, thr_ff};
   assign thr_mask      = ~({CW{1'b1}} << shift_amt);
   assign thr_scaled_in = (thr_ext >> shift_amt) + CW'(|(thr_ext & thr_mask));

   // largest rank sum for this size
   assign tri_prod = {{SW{1'b0}}, n_ff} * ({{SW{1'b0}}, n_ff} + (2*SW)'(1));
   assign top_in   = AW'(tri_prod >> 1);

   // per-rank upper sum bound and second read address
   assign hi_val    = (tri_ff > top_ff) ? top_ff : tri_ff;
   assign rd_b_addr = w_ff - AW'(i_ff);

   // running total and stop test
   assign rt_sum = rt_ff + rd_a_ff;
   assign hit    = (rt_sum >= thr_scaled_ff);

   // status to the sequencer
   always_comb begin
      flags.start     = start;
      flags.invalid   = (n_ff == '0) || (n_ff > SW'(MAX_SIZE));
      flags.w_eq_top  = (w_ff == top_ff);
      flags.w_eq_i    = (w_ff == AW'(i_ff));
      flags.i_eq_n    = (i_ff == n_ff);
      flags.scan_stop = hit || (w_ff == top_ff);
   end

   // sum index next value
   always_comb begin
      case (ctl.w_op)
         srq_pkg::W_HOLD: w_in = w_ff;
         srq_pkg::W_ZERO: w_in = '0;
         srq_pkg::W_INC:  w_in = w_ff + AW'(1);
         srq_pkg::W_DEC:  w_in = w_ff - AW'(1);
         srq_pkg::W_HI:   w_in = hi_val;
         srq_pkg::W_STEP: w_in = flags.scan_stop ? w_ff : w_ff + AW'(1);
         default:         w_in = w_ff;
      endcase
   end

   // rank counter and triangular bound
   always_comb begin
      case (ctl.i_op)
         srq_pkg::I_HOLD: begin
            i_in   = i_ff;
            tri_in = tri_ff;
         end
         srq_pkg::I_INIT: begin
            i_in   = SW'(1);
            tri_in = AW'(1);
         end
         srq_pkg::I_NEXT: begin
            i_in   = i_ff + SW'(1);
            tri_in = tri_ff + AW'(i_ff) + AW'(1);
         end
         default: begin
            i_in   = i_ff;
            tri_in = tri_ff;
         end
      endcase
   end

   // running total next value
   always_comb begin
      case (ctl.rt_op)
         srq_pkg::RT_HOLD: rt_in = rt_ff;
         srq_pkg::RT_ZERO: rt_in = '0;
         srq_pkg::RT_ACC:  rt_in = rt_sum;
         default:          rt_in = rt_ff;
      endcase
   end

   // working registers
   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      i_ff   <= i_in;
      tri_ff <= tri_in;
      if (ctl.i_op == srq_pkg::I_INIT) begin
         top_ff        <= top_in;
         thr_scaled_ff <= thr_scaled_in;
      end
      wr_addr_ff <= w_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         rt_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_ff      <= ctl.rmw;
         rt_ff        <= rt_in;
         rsp_valid_ff <= ctl.out_fire;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (ctl.out_fire) begin
         rsp_margin_ff <= ctl.out_zero ? '0 : srq_pkg::MARGIN_W'(w_ff);
      end
   end

   // count store: one write, two registered reads a cycle
   always_ff @(posedge clock) begin
      if (ctl.clr_wr) begin
         sum_counts_ff[w_ff] <= (w_ff == '0) ? CW'(1) : '0;
      end else if (pend_ff) begin
         sum_counts_ff[wr_addr_ff] <= rd_a_ff + rd_b_ff;
      end
      rd_a_ff <= sum_counts_ff[w_ff];
      rd_b_ff <= sum_counts_ff[rd_b_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_margin = rsp_margin_ff;

endmodule

`default_nettype wire

// ===== design/signed_rank_quantile_core.sv =====
// top level of the signed-rank quantile core: sequencer plus datapath
//
// channel   direction  ports                                 handshake
// request   in         req_sample_size, req_threshold        start high, busy low
// result    out        rsp_margin                            rsp_valid, one cycle
//
// one word in gives one word out; with T = n(n+1)/2 a valid request clears the T+1 count
// entries, updates each rank's entries, then scans the running total up to the margin; its
// run time is set by the one-write-a-cycle count store update.
// a size of 0 or above MAX_SIZE skips these steps and returns a margin of 0.
// reset is synchronous and clears the step counter, running total and strobe.
// the receiver cannot stall: rsp_valid is high for one cycle as busy falls.
`default_nettype none

module signed_rank_quantile_core #(
   parameter int MAX_SIZE = srq_pkg::MAX_SIZE_D
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire [srq_pkg::SIZE_W-1:0]     req_sample_size,
   input  wire [srq_pkg::THRESH_W-1:0]   req_threshold,
   output logic                          rsp_valid,
   output logic [srq_pkg::MARGIN_W-1:0]  rsp_margin
);

   srq_pkg::ctl_word_type ctl;
   srq_pkg::flags_type    flags;
   logic                  accept;

   assign accept = start && !busy;

   // control
   srq_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .busy  (busy)
   );

   // datapath
   srq_datapath #(
      .MAX_SIZE (MAX_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .start           (start),
      .req_sample_size (req_sample_size),
      .req_threshold   (req_threshold),
      .ctl             (ctl),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_margin      (rsp_margin)
   );

   // an accepted word makes the block busy next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("busy not raised after accepted word");

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(busy))
      else $error("result strobe without a job");

   // the result strobe marks the end of the job
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // the result strobe lasts a single cycle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking bench for the signed-rank quantile core with its own margin predictor
module tb;

   localparam int SUM_TOP = srq_pkg::MAX_SIZE_D * (srq_pkg::MAX_SIZE_D + 1) / 2;
   localparam logic [srq_pkg::THRESH_W-1:0] THRESH_MAX = {srq_pkg::THRESH_W{1'b1}};
   localparam logic [srq_pkg::THRESH_W-1:0] THRESH_HALF =
      {1'b1, {(srq_pkg::THRESH_W-1){1'b0}}};
   localparam int RANDOM_WORDS = 82;

   typedef struct {
      logic [srq_pkg::SIZE_W-1:0]   size;
      logic [srq_pkg::THRESH_W-1:0] thr;
      bit                           drain_first;
   } quantile_request_type;

   typedef struct {
      logic [srq_pkg::SIZE_W-1:0]   size;
      logic [srq_pkg::THRESH_W-1:0] thr;
      logic [srq_pkg::MARGIN_W-1:0] margin;
   } margin_expectation_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [srq_pkg::SIZE_W-1:0]   req_sample_size = '0;
   logic [srq_pkg::THRESH_W-1:0] req_threshold = '0;
   logic busy;
   logic rsp_valid;
   logic [srq_pkg::MARGIN_W-1:0] rsp_margin;

   quantile_request_type   pending_requests[$];
   margin_expectation_type expected_margins[$];

   // predictor state: one count per rank sum and the scan total
   longint unsigned rank_counts[0:SUM_TOP];
   longint unsigned running_sum;

   int mismatch_count = 0;
   int accepted_count = 0;
   int margins_checked = 0;
   bit send_ok;

   signed_rank_quantile_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample_size (req_sample_size),
      .req_threshold   (req_threshold),
      .rsp_valid       (rsp_valid),
      .rsp_margin      (rsp_margin)
   );

   always #2 clock = ~clock;

   // exact distribution of the rank sum over all sign patterns
   function automatic void build_distribution(input int n);
      int top, hi, i, w;
      top = n * (n + 1) / 2;
      for (w = 0; w <= top; w++) rank_counts[w] = 0;
      rank_counts[0] = 1;
      for (i = 1; i <= n; i++) begin
         hi = i * (i + 1) / 2;
         if (hi > top) hi = top;
         for (w = hi; w >= i; w--) rank_counts[w] += rank_counts[w - i];
      end
   endfunction

   // smallest rank sum whose scaled cumulative count reaches the threshold
   function automatic logic [srq_pkg::MARGIN_W-1:0] predict_margin(
      input logic [srq_pkg::SIZE_W-1:0] size,
      input logic [srq_pkg::THRESH_W-1:0] thr);
      int n, top, w;
      n = size;
      if (n == 0 || n > srq_pkg::MAX_SIZE_D) return '0;
      build_distribution(n);
      top = n * (n + 1) / 2;
      running_sum = 0;
      for (w = 0; w <= top; w++) begin
         running_sum += rank_counts[w];
         if ((running_sum << (63 - n)) >= {1'b0, thr}) return w[srq_pkg::MARGIN_W-1:0];
      end
      return top[srq_pkg::MARGIN_W-1:0];
   endfunction

   // threshold sitting on, just under or just over the step at rank sum w
   function automatic logic [srq_pkg::THRESH_W-1:0] boundary_threshold(input int n,
                                                                       input int w,
                                                                       input int delta);
      longint unsigned cum, scaled;
      int k;
      build_distribution(n);
      cum = 0;
      for (k = 0; k <= w; k++) cum += rank_counts[k];
      scaled = cum << (63 - n);
      if (delta < 0) scaled = scaled - 1;
      else if (delta > 0) scaled = scaled + 1;
      if (scaled > {1'b0, THRESH_MAX}) scaled = {1'b0, THRESH_MAX};
      return scaled[srq_pkg::THRESH_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic add_request(input int size, input logic [srq_pkg::THRESH_W-1:0] thr,
                              input bit drain_first);
      quantile_request_type word;
      word.size = size[srq_pkg::SIZE_W-1:0];
      word.thr = thr;
      word.drain_first = drain_first;
      pending_requests.push_back(word);
   endtask

   // driver: present the next word, hold it until the block takes it
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_margins.push_back('{req_sample_size, req_threshold,
                                         predict_margin(req_sample_size, req_threshold)});
            accepted_count++;
         end
         send_ok = (accepted_count >= 60 && accepted_count < 95) ||
                   ($urandom_range(99) >= 35);
         if (start && busy) begin
            // word still waiting for the block
         end else if (pending_requests.size() != 0 && send_ok &&
                      !(pending_requests[0].drain_first && expected_margins.size() != 0)) begin
            start <= 1'b1;
            req_sample_size <= pending_requests[0].size;
            req_threshold <= pending_requests[0].thr;
            void'(pending_requests.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each strobed margin with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_margins.size() == 0) begin
            report_mismatch($sformatf("margin %0d with no request outstanding", rsp_margin));
         end else begin
            if (rsp_margin !== expected_margins[0].margin)
               report_mismatch($sformatf("size %0d threshold %h: margin %0d, want %0d",
                                         expected_margins[0].size, expected_margins[0].thr,
                                         rsp_margin, expected_margins[0].margin));
            void'(expected_margins.pop_front());
            margins_checked++;
         end
      end
   end

   initial begin
      int r, n, top, full_count, zero_count;
      logic [63:0] raw;
      logic [srq_pkg::THRESH_W-1:0] thr;

      // directed words: size and threshold extremes, steps of the distribution
      add_request(0, '0, 1'b0);
      add_request(0, THRESH_MAX, 1'b0);
      add_request(1, '0, 1'b0);
      add_request(1, THRESH_MAX, 1'b0);
      add_request(1, THRESH_HALF, 1'b0);
      add_request(1, THRESH_HALF + 1'b1, 1'b0);
      add_request(2, boundary_threshold(2, 1, 0), 1'b0);
      add_request(2, boundary_threshold(2, 1, 1), 1'b0);
      add_request(3, boundary_threshold(3, 2, -1), 1'b0);
      add_request(10, {32'h2AAA_AAAA, 31'h2AAA_AAAA}, 1'b0);
      add_request(10, {32'h5555_5555, 31'h5555_5555}, 1'b0);
      add_request(32, boundary_threshold(32, 264, 0), 1'b0);
      add_request(32, boundary_threshold(32, 264, 1), 1'b0);
      add_request(63, '0, 1'b1);
      add_request(63, THRESH_MAX, 1'b0);
      add_request(63, THRESH_HALF, 1'b0);
      add_request(62, boundary_threshold(62, 700, -1), 1'b0);
      add_request(0, THRESH_HALF, 1'b1);

      // random words: mostly small sizes, thresholds often on a step edge
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         r = $urandom_range(99);
         if (r < 3) n = 0;
         else if (r < 6) n = $urandom_range(63, 45);
         else if (r < 14) n = $urandom_range(44, 25);
         else n = $urandom_range(24, 1);
         top = n * (n + 1) / 2;
         raw = {$urandom, $urandom};
         r = $urandom_range(99);
         if (n != 0 && r < 45)
            thr = boundary_threshold(n, $urandom_range(top, 0), $urandom_range(2, 0) - 1);
         else if (r < 65) thr = raw[srq_pkg::THRESH_W-1:0];
         else if (r < 78) thr = raw[srq_pkg::THRESH_W-1:0] >> $urandom_range(62, 40);
         else if (r < 90)
            thr = THRESH_HALF ^ (raw[srq_pkg::THRESH_W-1:0] >> $urandom_range(62, 20));
         else thr = THRESH_MAX - (raw[srq_pkg::THRESH_W-1:0] >> $urandom_range(62, 30));
         add_request(n, thr, $urandom_range(99) < 5);
      end

      full_count = 0;
      zero_count = 0;
      foreach (pending_requests[k]) begin
         if (pending_requests[k].size == srq_pkg::MAX_SIZE_D) full_count++;
         if (pending_requests[k].size == 0) zero_count++;
      end
      n = pending_requests.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to be taken, then for the last margin
      while (accepted_count < n) @(posedge clock);
      while (expected_margins.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d requests (%0d of size zero, %0d at full size)",
               n, zero_count, full_count);
      $display("compared %0d margins, %0d mismatches", margins_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog well beyond the slowest expected run
   initial begin
      #40000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/srq_pkg.sv
design/srq_sequencer.sv
design/srq_datapath.sv
design/signed_rank_quantile_core.sv
tb/tb.sv
